// ===== src/prq_pkg.sv =====
// Package with the types and constants shared by the ready queue modules.
package prq_pkg;

   localparam int DEPTH   = 16;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int ID_W    = 8;
   localparam int PRIO_W  = 8;
   localparam int OCC_W   = 5;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      logic              kind;
      logic [ID_W-1:0]   proc_id;
      logic [PRIO_W-1:0] prio;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   out_id;
      logic [PRIO_W-1:0] out_prio;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic      insert_en;
      logic      remove_en;
      entry_type new_entry;
   } cell_ctrl_type;

   typedef struct packed {
      logic goes_after;
      logic dup;
   } cell_flags_type;

endpackage

// ===== src/prq_cell.sv =====
// One queue cell: holds an entry, compares it with the new one and shifts.
module prq_cell (
   input  logic                   clock,
   input  prq_pkg::cell_ctrl_type ctrl_i,
   input  logic                   occupied_i,
   input  logic                   left_after_i,
   input  prq_pkg::entry_type     left_entry_i,
   input  prq_pkg::entry_type     right_entry_i,
   output prq_pkg::entry_type     entry_o,
   output prq_pkg::cell_flags_type flags_o
);
   import prq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      goes_after;

   assign goes_after = occupied_i && (entry_ff.prio <= ctrl_i.new_entry.prio);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl_i.insert_en && !goes_after) begin
         entry_in = left_after_i ? ctrl_i.new_entry : left_entry_i;
      end else if (ctrl_i.remove_en) begin
         entry_in = right_entry_i;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_o            = entry_ff;
   assign flags_o.goes_after = goes_after;
   assign flags_o.dup        = occupied_i && (entry_ff.id == ctrl_i.new_entry.id);

endmodule

// ===== src/priority_ready_queue.sv =====
// Top level of the sorted ready queue: a row of shifting cells and a result register.
// The result of an accepted item is registered and presented in the cycle after its transfer.
// One item per cycle unless a result waits; all cells compare with the new item in parallel.
// Reset clears the entry count and the result valid; cell contents are left as they are.
// No clearing pass is needed, so the block accepts items in the first cycle after reset.
module priority_ready_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  prq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output prq_pkg::rsp_type rsp_data
);
   import prq_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;

   entry_type          entries [DEPTH];
   cell_flags_type     flags   [DEPTH];
   logic [DEPTH-1:0]   occupied;
   logic [DEPTH-1:0]   after_vec;
   logic [DEPTH-1:0]   dup_vec;
   cell_ctrl_type      ctrl;

   logic fire;
   logic any_dup;
   logic full;
   logic empty;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign any_dup   = |dup_vec;
   assign full      = (count_ff == COUNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   assign ctrl.insert_en        = fire && (req_data.kind == KIND_INSERT) && !any_dup && !full;
   assign ctrl.remove_en        = fire && (req_data.kind == KIND_REMOVE) && !empty;
   assign ctrl.new_entry.id     = req_data.proc_id;
   assign ctrl.new_entry.prio   = req_data.prio;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic      left_after;
         entry_type left_entry;
         entry_type right_entry;

         assign occupied[i]  = (COUNT_W'(i) < count_ff);
         assign after_vec[i] = flags[i].goes_after;
         assign dup_vec[i]   = flags[i].dup;

         if (i == 0) begin : g_head
            assign left_after = 1'b1;
            assign left_entry = ctrl.new_entry;
         end else begin : g_body
            assign left_after = after_vec[i-1];
            assign left_entry = entries[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign right_entry = entries[i];
         end else begin : g_inner
            assign right_entry = entries[i+1];
         end

         prq_cell u_cell (
            .clock         (clock),
            .ctrl_i        (ctrl),
            .occupied_i    (occupied[i]),
            .left_after_i  (left_after),
            .left_entry_i  (left_entry),
            .right_entry_i (right_entry),
            .entry_o       (entries[i]),
            .flags_o       (flags[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert_en) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (ctrl.remove_en) begin
         count_in = count_ff - COUNT_W'(1);
      end

      rsp_data_in           = rsp_data_ff;
      rsp_data_in.out_id    = '0;
      rsp_data_in.out_prio  = '0;
      rsp_data_in.occupancy = OCC_W'(count_in);
      if (req_data.kind == KIND_INSERT) begin
         if (any_dup) begin
            rsp_data_in.status = ST_DUPLICATE;
         end else if (full) begin
            rsp_data_in.status = ST_FULL;
         end else begin
            rsp_data_in.status = ST_INSERTED;
         end
      end else begin
         if (empty) begin
            rsp_data_in.status = ST_EMPTY;
         end else begin
            rsp_data_in.status   = ST_REMOVED;
            rsp_data_in.out_id   = entries[0].id;
            rsp_data_in.out_prio = entries[0].prio;
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("Entry count exceeds the queue depth.");

   a_single_match : assert property (@(posedge clock) disable iff (reset)
      $onehot0(dup_vec))
      else $error("A process id is held in more than one cell.");

   a_insert_count : assert property (@(posedge clock) disable iff (reset)
      ctrl.insert_en |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("Entry count did not grow after an insert.");

   a_empty_occupancy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == ST_EMPTY) |-> rsp_data_ff.occupancy == '0)
      else $error("Empty result reports a non-zero occupancy.");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the sorted ready queue, with a scoreboard class and driver tasks.
module tb;
   import prq_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 5;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 4;

   class queue_scoreboard;
      entry_type ready_list[$];
      rsp_type awaited[$];
      int errors = 0;

      task report(input string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function void note_request(input req_type item);
         rsp_type want;
         entry_type fresh;
         entry_type head;
         bit dup;
         int pos;
         want = '0;
         dup = 1'b0;
         foreach (ready_list[i]) begin
            if (ready_list[i].id == item.proc_id) begin
               dup = 1'b1;
            end
         end
         if (item.kind == KIND_INSERT) begin
            if (dup) begin
               want.status = ST_DUPLICATE;
            end else if (ready_list.size() >= DEPTH) begin
               want.status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < ready_list.size() && ready_list[pos].prio <= item.prio) begin
                  pos++;
               end
               fresh.id = item.proc_id;
               fresh.prio = item.prio;
               ready_list.insert(pos, fresh);
               want.status = ST_INSERTED;
            end
         end else begin
            if (ready_list.size() == 0) begin
               want.status = ST_EMPTY;
            end else begin
               head = ready_list.pop_front();
               want.out_id = head.id;
               want.out_prio = head.prio;
               want.status = ST_REMOVED;
            end
         end
         want.occupancy = OCC_W'(ready_list.size());
         awaited.push_back(want);
      endfunction

      task check_response(input rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            report($sformatf("response with no request outstanding: %h", got));
         end else begin
            want = awaited.pop_front();
            if (got.status != want.status) begin
               report($sformatf("status %0d, expected %0d", got.status, want.status));
            end
            if (got.out_id != want.out_id) begin
               report($sformatf("out_id %0d, expected %0d", got.out_id, want.out_id));
            end
            if (got.out_prio != want.out_prio) begin
               report($sformatf("out_prio %0d, expected %0d", got.out_prio, want.out_prio));
            end
            if (got.occupancy != want.occupancy) begin
               report($sformatf("occupancy %0d, expected %0d", got.occupancy,
                                want.occupancy));
            end
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   queue_scoreboard book = new;
   int send_idle_pct = 11;
   int recv_idle_pct = 84;
   bit hold_wanted = 1'b0;
   bit hold_done = 1'b0;
   int stall_cycles = 0;

   priority_ready_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // The receiver holds off once for a long stretch so that the input is stalled.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            book.note_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            book.check_response(rsp_data);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("Testbench completed WITH ERRORS");
               $finish;
            end
         end
      end
   end

   task automatic send_request(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic kind, input logic [7:0] id, input logic [7:0] prio);
      req_type item;
      item.kind = kind;
      item.proc_id = id;
      item.prio = prio;
      send_request(item);
   endtask

   task automatic run_random_phase(input int item_count);
      req_type item;
      int insert_pct;
      int n;
      insert_pct = 50;
      for (n = 0; n < item_count; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: insert_pct = 15;
               1: insert_pct = 50;
               default: insert_pct = 85;
            endcase
         end
         item.kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
         item.proc_id = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 23))
                                                     : 8'($urandom_range(0, 255));
         item.prio = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3))
                                                 : 8'($urandom_range(0, 255));
         send_request(item);
      end
   endtask

   initial begin
      logic [7:0] fill_prio [16];
      int k;
      fill_prio = '{8'd255, 8'd0, 8'd0, 8'd128, 8'd1, 8'd255, 8'd0, 8'd64,
                    8'd2, 8'd200, 8'd0, 8'd255, 8'd16, 8'd32, 8'd0, 8'd8};
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_fields(KIND_REMOVE, 8'hA5, 8'h5A);
      for (k = 0; k < DEPTH; k++) begin
         send_fields(KIND_INSERT, 8'(k * 17), fill_prio[k]);
         if (k == 2) begin
            send_fields(KIND_INSERT, 8'd0, 8'd3);
         end
      end
      send_fields(KIND_INSERT, 8'd1, 8'd0);
      send_fields(KIND_INSERT, 8'd255, 8'd9);
      send_fields(KIND_REMOVE, 8'hFF, 8'hFF);
      send_fields(KIND_REMOVE, 8'h00, 8'h00);

      run_random_phase(620);

      send_idle_pct = 84;
      recv_idle_pct = 11;
      run_random_phase(620);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_wanted = 1'b1;
      run_random_phase(610);

      req_valid <= 1'b0;
      while (book.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
